// File: hw/rtl/stack_queue_opcode_engine_top_defines.svh
// assertion macros for the stack/queue opcode engine
// used by stack_queue_opcode_engine_top, expects clk and rst_n in scope
`ifndef STACK_QUEUE_OPCODE_ENGINE_TOP_DEFINES_SVH
`define STACK_QUEUE_OPCODE_ENGINE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SQOE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sqoe same-cycle check failed");
`define SQOE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sqoe next-cycle check failed");
`else
`define SQOE_ASSERT_SAME(label, ante, cons)
`define SQOE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/sqoe_pkg.sv
// shared types and constants for the stack/queue opcode engine
// no dependencies
package sqoe_pkg;

    localparam int SQOE_STACK_DEPTH = 64;
    localparam int DATA_W           = 32;

    typedef enum logic [2:0] {
        OP_PUSH      = 3'd0,
        OP_PRINT_ALL = 3'd1,
        OP_PRINT_TOP = 3'd2,
        OP_POP       = 3'd3,
        OP_SWAP      = 3'd4,
        OP_ADD       = 3'd5,
        OP_NOP       = 3'd6
    } opcode_e_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_SHORT = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ACT_HOLD,
        ACT_PUSH_TOP,
        ACT_PUSH_BOTTOM,
        ACT_POP,
        ACT_SWAP,
        ACT_ADD,
        ACT_ROTATE
    } cell_action_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_PRINT
    } fsm_state_t;

endpackage

// File: hw/rtl/sqoe_cell.sv
// one entry of the shift chain, position INDEX below the top
// depends on sqoe_pkg
module sqoe_cell
    import sqoe_pkg::*;
#(
    parameter int STACK_DEPTH = SQOE_STACK_DEPTH,
    parameter int INDEX       = 0
)
(
    input  logic                                 clk,
    input  cell_action_t                         action,
    input  logic [$clog2(STACK_DEPTH + 1) - 1:0] count,
    input  logic [DATA_W - 1:0]                  push_value,
    input  logic [DATA_W - 1:0]                  from_above,
    input  logic [DATA_W - 1:0]                  from_below,
    input  logic [DATA_W - 1:0]                  wrap_value,
    output logic [DATA_W - 1:0]                  value
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DATA_W - 1:0] value_reg;
    logic [DATA_W - 1:0] value_next;
    logic                at_count;
    logic                at_bottom;

    assign at_count  = (count == CW'(INDEX));
    assign at_bottom = (count == CW'(INDEX + 1));

    always_comb
    begin
        value_next = value_reg;
        case (action)
            ACT_PUSH_TOP:
            begin
                value_next = (INDEX == 0) ? push_value : from_above;
            end
            ACT_PUSH_BOTTOM:
            begin
                if (at_count)
                begin
                    value_next = push_value;
                end
            end
            ACT_POP:
            begin
                value_next = from_below;
            end
            ACT_SWAP:
            begin
                if (INDEX == 0)
                begin
                    value_next = from_below;
                end
                else if (INDEX == 1)
                begin
                    value_next = from_above;
                end
            end
            ACT_ADD:
            begin
                // top takes the wrapped sum, the rest close the gap
                value_next = (INDEX == 0) ? value_reg + from_below : from_below;
            end
            ACT_ROTATE:
            begin
                // top entry moves to the bottom live slot
                value_next = at_bottom ? wrap_value : from_below;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: hw/rtl/sqoe_ctrl.sv
// opcode decode, entry count, print-all sequencer and result registers
// depends on sqoe_pkg
module sqoe_ctrl
    import sqoe_pkg::*;
#(
    parameter int STACK_DEPTH = SQOE_STACK_DEPTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [2:0]                           opcode,
    input  logic                                 queue_mode_we,
    input  logic                                 queue_mode_wdata,
    input  logic [DATA_W - 1:0]                  top_value,
    output logic                                 busy,
    output cell_action_t                         action,
    output logic [$clog2(STACK_DEPTH + 1) - 1:0] count,
    output logic                                 result_strobe,
    output logic [DATA_W - 1:0]                  data,
    output logic                                 has_value,
    output logic [1:0]                           status,
    output logic                                 last
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    fsm_state_t          state_reg, state_next;
    logic [CW - 1:0]     count_reg, count_next;
    logic [CW - 1:0]     idx_reg, idx_next;
    logic                queue_mode_reg;
    logic                strobe_reg, strobe_next;
    logic [DATA_W - 1:0] data_reg, data_next;
    logic                has_reg, has_next;
    status_t             status_reg, status_next;
    logic                last_reg, last_next;
    logic                accept;
    logic                print_step;
    logic                print_last;
    logic [CW - 1:0]     idx_cur;

    assign busy    = (state_reg == FSM_PRINT);
    assign accept  = start && !busy;
    assign idx_cur = busy ? idx_reg : '0;
    assign print_last = (idx_cur == count_reg - CW'(1));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        action      = ACT_HOLD;
        strobe_next = 1'b0;
        data_next   = '0;
        has_next    = 1'b0;
        status_next = ST_OK;
        last_next   = 1'b1;
        print_step  = 1'b0;

        if (busy)
        begin
            print_step = 1'b1;
        end
        else if (accept)
        begin
            strobe_next = 1'b1;
            case (opcode_e_t'(opcode))
                OP_PUSH:
                begin
                    if (count_reg == CW'(STACK_DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        action     = queue_mode_reg ? ACT_PUSH_BOTTOM : ACT_PUSH_TOP;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_PRINT_ALL:
                begin
                    if (count_reg != '0)
                    begin
                        print_step = 1'b1;
                    end
                end
                OP_PRINT_TOP:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        data_next = top_value;
                        has_next  = 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        action     = ACT_POP;
                        count_next = count_reg - CW'(1);
                    end
                end
                OP_SWAP:
                begin
                    if (count_reg < CW'(2))
                    begin
                        status_next = ST_SHORT;
                    end
                    else
                    begin
                        action = ACT_SWAP;
                    end
                end
                OP_ADD:
                begin
                    if (count_reg < CW'(2))
                    begin
                        status_next = ST_SHORT;
                    end
                    else
                    begin
                        action     = ACT_ADD;
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end

        // one entry per cycle from the top cell, chain rotates back into order
        if (print_step)
        begin
            action      = ACT_ROTATE;
            strobe_next = 1'b1;
            data_next   = top_value;
            has_next    = 1'b1;
            last_next   = print_last;
            idx_next    = print_last ? '0 : idx_cur + CW'(1);
            state_next  = print_last ? FSM_IDLE : FSM_PRINT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            queue_mode_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
            if (queue_mode_we)
            begin
                queue_mode_reg <= queue_mode_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        has_reg    <= has_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign count         = count_reg;
    assign result_strobe = strobe_reg;
    assign data          = data_reg;
    assign has_value     = has_reg;
    assign status        = status_reg;
    assign last          = last_reg;

endmodule

// File: hw/rtl/stack_queue_opcode_engine_top.sv
// Stack/queue opcode engine. An item is taken when start is high and busy low;
// its result is on the result ports in the next cycle for one cycle, marked by
// result_strobe, and cannot be held off. Push, pop, print top, swap, add and
// no-op never raise busy, so a new item can follow every cycle. Print all
// gives one result per stored entry (one when empty): entries sit in a chain
// of STACK_DEPTH cells, top in cell zero, and are read out of cell zero as the
// chain rotates once round its live entries; busy is high for later entries.
// queue_mode is written via queue_mode_we / queue_mode_wdata, by the user only
// when idle (not enforced); depends on sqoe_pkg, sqoe_cell, sqoe_ctrl, defines
`include "stack_queue_opcode_engine_top_defines.svh"

module stack_queue_opcode_engine_top
    import sqoe_pkg::*;
#(
    parameter int STACK_DEPTH = SQOE_STACK_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  opcode,
    input  logic signed [DATA_W - 1:0]  push_value,
    input  logic                        queue_mode_we,
    input  logic                        queue_mode_wdata,
    output logic                        result_strobe,
    output logic signed [DATA_W - 1:0]  data,
    output logic                        has_value,
    output logic [1:0]                  status,
    output logic                        last
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    cell_action_t        action;
    logic [CW - 1:0]     count;
    logic [DATA_W - 1:0] cell_value [STACK_DEPTH];
    logic [DATA_W - 1:0] data_u;

    sqoe_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .opcode           (opcode),
        .queue_mode_we    (queue_mode_we),
        .queue_mode_wdata (queue_mode_wdata),
        .top_value        (cell_value[0]),
        .busy             (busy),
        .action           (action),
        .count            (count),
        .result_strobe    (result_strobe),
        .data             (data_u),
        .has_value        (has_value),
        .status           (status),
        .last             (last)
    );

    assign data = data_u;

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [DATA_W - 1:0] above;
        logic [DATA_W - 1:0] below;

        if (i == 0)
        begin : g_first
            assign above = '0;
        end
        else
        begin : g_mid_above
            assign above = cell_value[i - 1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_end
            assign below = '0;
        end
        else
        begin : g_mid_below
            assign below = cell_value[i + 1];
        end

        sqoe_cell #(
            .STACK_DEPTH (STACK_DEPTH),
            .INDEX       (i)
        ) u_cell (
            .clk        (clk),
            .action     (action),
            .count      (count),
            .push_value (push_value),
            .from_above (above),
            .from_below (below),
            .wrap_value (cell_value[0]),
            .value      (cell_value[i])
        );
    end

    `SQOE_ASSERT_SAME(a_count_bound, 1'b1, count <= CW'(STACK_DEPTH))
    `SQOE_ASSERT_SAME(a_busy_not_empty, busy, count != '0)
    `SQOE_ASSERT_SAME(a_more_follows, result_strobe && !last, busy)
    `SQOE_ASSERT_NEXT(a_pop_empty, start && !busy && opcode == OP_POP && count == '0, result_strobe && status == ST_EMPTY)

endmodule
